FILE: hdl/llev_pkg.sv
// Shared types and constants for the lat/long entry validator.
// Item structs, validator state, character class codes and register indexes.
// No dependencies.
package llev_pkg;

	localparam int CP_W      = 21;
	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = 4;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_NORTH_UPPER = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EAST_UPPER  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_UPPER = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WEST_UPPER  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NORTH_LOWER = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_EAST_LOWER  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_LOWER = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_WEST_LOWER  = 4'd7;

	localparam logic [CP_W-1:0] CFG_RESET [NUM_CFG] = '{
		21'h4E, 21'h45, 21'h53, 21'h57, 21'h6E, 21'h65, 21'h73, 21'h77
	};

	// code points with a fixed meaning
	localparam logic [CP_W-1:0] CP_GON    = 21'h67;
	localparam logic [CP_W-1:0] CP_POINT  = 21'h2E;
	localparam logic [CP_W-1:0] CP_PLUS   = 21'h2B;
	localparam logic [CP_W-1:0] CP_MINUS  = 21'h2D;
	localparam logic [CP_W-1:0] CP_DEGREE = 21'hB0;
	localparam logic [CP_W-1:0] CP_PRIME  = 21'h2032;
	localparam logic [CP_W-1:0] CP_DPRIME = 21'h2033;
	localparam logic [CP_W-1:0] CP_APOS   = 21'h27;
	localparam logic [CP_W-1:0] CP_QUOTE  = 21'h22;
	localparam logic [CP_W-1:0] CP_SPACE  = 21'h20;
	localparam logic [CP_W-1:0] CP_TAB    = 21'h09;
	localparam logic [CP_W-1:0] CP_CR     = 21'h0D;
	localparam logic [CP_W-1:0] CP_ZERO   = 21'h30;
	localparam logic [CP_W-1:0] CP_NINE   = 21'h39;

	typedef enum logic [2:0] {
		K_DIGIT,
		K_GON,
		K_SIGN,
		K_MARK,
		K_POINT,
		K_OTHER
	} kind_t;

	typedef struct packed {
		logic [CP_W-1:0] char_code;
		logic            first_char;
	} in_item_t;

	typedef struct packed {
		logic       text_ok;
		logic [1:0] angles_seen;
	} out_item_t;

	typedef struct packed {
		logic       failed;
		logic [1:0] closed_angles;
		logic [1:0] ns_letters;
		logic [1:0] ew_letters;
		logic       angle_nonempty;
		logic       prev_was_digit;
		logic       gon_seen;
		logic [2:0] mark_count;
		logic [1:0] point_count;
		logic [1:0] marks_after_point;
	} val_state_t;

endpackage

FILE: hdl/latlong_entry_validator.sv
// Lat/long entry validator top level: input register, check logic, result register.
// Depends on llev_pkg.
//
// Takes one code point per item and returns one result per item: whether the
// text so far is a valid partial latitude/longitude entry, and how many
// nonempty angles it holds. A new item is taken every cycle while in_stall is
// low; the item is held in the input register, and its result is loaded into
// the result register when that register is free. The next state of the checks
// is computed combinationally from the registered item. A stall on the output
// backs up into in_stall once both registers hold items. Set first_char on the
// first item of each new text. Write the compass letter registers only while no
// item is in flight.
module latlong_entry_validator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  llev_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output llev_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [llev_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [llev_pkg::CP_W-1:0]         cfg_data
);
	import llev_pkg::*;

	logic [CP_W-1:0] cfg_q [NUM_CFG];
	val_state_t      st_q;
	val_state_t      st_b;
	val_state_t      st_n;
	in_item_t        item_s1;
	logic            valid_s1;
	out_item_t       res_s2;
	logic            valid_s2;
	out_item_t       res_n;

	logic            s2_free;
	logic            advance;
	logic            in_accept;
	logic [NUM_CFG-1:0] match;
	logic            is_letter;
	logic            axis_ew;
	logic            is_space;
	kind_t           kind;
	logic [CP_W-1:0] c;
	logic [2:0]      map_sum;
	logic [2:0]      total;

	assign s2_free   = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// configuration registers; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
			cfg_q[cfg_index[$clog2(NUM_CFG)-1:0]] <= cfg_data;
		end
	end

	assign c = item_s1.char_code;

	// compass letter compare; highest matching slot picks the axis
	always_comb begin
		axis_ew = 1'b0;
		for (int i = 0; i < NUM_CFG; i++) begin
			match[i] = (c == cfg_q[i]);
			if (match[i]) begin
				axis_ew = 1'(i % 2);
			end
		end
		is_letter = |match;
		is_space  = (c == CP_SPACE) || ((c >= CP_TAB) && (c <= CP_CR));
	end

	always_comb begin
		st_b = item_s1.first_char ? '0 : st_q;
		if ((c == CP_DEGREE) || (c == CP_PRIME) || (c == CP_DPRIME) ||
				(c == CP_APOS) || (c == CP_QUOTE)) begin
			kind = K_MARK;
		end else if (c == CP_MINUS) begin
			kind = st_b.angle_nonempty ? K_MARK : K_SIGN;
		end else if (c == CP_PLUS) begin
			kind = K_SIGN;
		end else if ((c >= CP_ZERO) && (c <= CP_NINE)) begin
			kind = K_DIGIT;
		end else if (c == CP_GON) begin
			kind = K_GON;
		end else if (c == CP_POINT) begin
			kind = K_POINT;
		end else begin
			kind = K_OTHER;
		end
	end

	// next state for the registered item
	always_comb begin
		st_n    = st_b;
		map_sum = {1'b0, st_b.marks_after_point} + {1'b0, st_b.point_count};
		if (is_letter || is_space) begin
			if (is_letter) begin
				if (axis_ew) begin
					if (st_b.ew_letters != 2'd3) st_n.ew_letters = st_b.ew_letters + 2'd1;
					if (st_n.ew_letters > 2'd1) st_n.failed = 1'b1;
				end else begin
					if (st_b.ns_letters != 2'd3) st_n.ns_letters = st_b.ns_letters + 2'd1;
					if (st_n.ns_letters > 2'd1) st_n.failed = 1'b1;
				end
			end
			if (st_b.angle_nonempty && (st_b.closed_angles != 2'd3)) begin
				st_n.closed_angles = st_b.closed_angles + 2'd1;
			end
			st_n.angle_nonempty    = 1'b0;
			st_n.prev_was_digit    = 1'b0;
			st_n.gon_seen          = 1'b0;
			st_n.mark_count        = '0;
			st_n.point_count       = '0;
			st_n.marks_after_point = '0;
		end else begin
			if (st_b.gon_seen) st_n.failed = 1'b1;
			// a third angle is starting
			if (!st_b.angle_nonempty && (st_b.closed_angles >= 2'd2)) st_n.failed = 1'b1;
			case (kind)
				K_OTHER: begin
					st_n.failed = 1'b1;
				end
				K_SIGN: begin
					if (st_b.angle_nonempty) st_n.failed = 1'b1;
				end
				K_MARK: begin
					if (!st_b.prev_was_digit) st_n.failed = 1'b1;
					if (st_b.mark_count != 3'd7) st_n.mark_count = st_b.mark_count + 3'd1;
					if (st_n.mark_count > 3'd3) st_n.failed = 1'b1;
					st_n.marks_after_point = (map_sum > 3'd3) ? 2'd3 : map_sum[1:0];
					if (st_n.marks_after_point > 2'd1) st_n.failed = 1'b1;
				end
				K_POINT: begin
					if (st_b.point_count != 2'd3) st_n.point_count = st_b.point_count + 2'd1;
					if (st_n.point_count > 2'd1) st_n.failed = 1'b1;
				end
				K_GON: begin
					st_n.gon_seen = 1'b1;
					if (st_b.mark_count != 3'd0) st_n.failed = 1'b1;
				end
				default: begin
				end
			endcase
			st_n.prev_was_digit = (kind == K_DIGIT);
			st_n.angle_nonempty = 1'b1;
		end
		total = {1'b0, st_n.closed_angles} + {2'b00, st_n.angle_nonempty};
		res_n.text_ok     = !st_n.failed;
		res_n.angles_seen = (total > 3'd3) ? 2'd3 : total[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q     <= st_n;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers: load the item on accept, the result on advance
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_s2 <= res_n;
		end
	end

endmodule
